FILE: sv/gcom_pkg.sv
// gcom_pkg: types, constants and register codes for the grid cell overlap mapper.
// Used by every module of the block; depends on nothing.
package gcom_pkg;

  // Defaults for the top level's grid size parameters
  localparam int MAX_TGT_ROWS_DEF = 8;
  localparam int MAX_TGT_COLS_DEF = 8;

  // Fixed widths
  localparam int CFG_IDX_W = 4;   // register index on the config port
  localparam int COORD_W   = 36;  // cell edges: origin plus up to 8 cells of 31 bits
  localparam int IDX_W     = 3;   // target row and column index
  localparam int Q_DEPTH   = 4;   // front-to-back queue entries

  localparam logic [47:0] WEIGHT_MAX = 48'hFFFF_FFFF_FFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 4'd0,
    CFG_ORIGIN_Y  = 4'd1,
    CFG_CELL_W    = 4'd2,
    CFG_CELL_H    = 4'd3,
    CFG_ROWS      = 4'd4,
    CFG_COLS      = 4'd5,
    CFG_FPA       = 4'd6,
    CFG_ROW_ORDER = 4'd7
  } cfg_idx_t;

  // Input word: source rectangle and tags
  typedef struct packed {
    logic signed [31:0] src_x_lo;
    logic signed [31:0] src_x_hi;
    logic signed [31:0] src_y_lo;
    logic signed [31:0] src_y_hi;
    logic [7:0]         src_row;
    logic [7:0]         src_col;
  } gcom_in_t;

  // Result word: one fragment or the empty result
  typedef struct packed {
    logic [7:0]       tag_row;
    logic [7:0]       tag_col;
    logic [IDX_W-1:0] tgt_row;
    logic [IDX_W-1:0] tgt_col;
    logic [47:0]      weight;
    logic             saturated;
    logic             no_overlap;
    logic             last;
  } gcom_out_t;

  // Configuration register file as seen by the datapath
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [30:0]        cell_w;
    logic [30:0]        cell_h;
    logic [3:0]         rows;
    logic [3:0]         cols;
    logic [31:0]        fpa;
    logic               row_order;
  } gcom_cfg_t;

  // Queue entry: an overlapping cell, or the end-of-walk marker
  typedef struct packed {
    logic             is_end;
    logic [31:0]      dx;
    logic [31:0]      dy;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } gcom_frag_t;

  // Queue status toward producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } gcom_q_stat_t;

  // Front walker states
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_WALK,
    FR_END
  } fr_state_t;

endpackage

FILE: sv/gcom_front.sv
// gcom_front: takes a source rectangle, walks the target grid one cell a cycle unless
// the queue is full, queues overlapping cells' extents, then an end marker. Uses gcom_pkg.
module gcom_front
  import gcom_pkg::*;
#(
  parameter int MAX_TGT_ROWS = MAX_TGT_ROWS_DEF,
  parameter int MAX_TGT_COLS = MAX_TGT_COLS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  gcom_in_t     in_data,
  input  gcom_cfg_t    cfg,
  input  gcom_q_stat_t q_stat,
  output logic         push,
  output gcom_frag_t   push_data,
  output logic [7:0]   tag_row,
  output logic [7:0]   tag_col
);

  fr_state_t state_r, state_nxt;

  logic [IDX_W-1:0] h_r, k_r, last_row_r, last_col_r;
  logic signed [31:0] ax_r, bx_r, ay_r, by_r;
  logic signed [COORD_W-1:0] px_r, qx_r, py_r, qy_r, y0_r, y1_r;
  logic [7:0] tag_row_r, tag_col_r;

  // Clamp the counts in use
  logic [3:0] rows_c, cols_c;
  logic [IDX_W-1:0] rows_m1, cols_m1;
  assign rows_c  = (cfg.rows > 4'(MAX_TGT_ROWS)) ? 4'(MAX_TGT_ROWS) : cfg.rows;
  assign cols_c  = (cfg.cols > 4'(MAX_TGT_COLS)) ? 4'(MAX_TGT_COLS) : cfg.cols;
  assign rows_m1 = IDX_W'(rows_c - 4'd1);
  assign cols_m1 = IDX_W'(cols_c - 4'd1);

  // Extended cell size and origin
  logic signed [COORD_W-1:0] w_e, ht_e, ox_e, oy_e, ytop_e;
  logic [33:0] ytop_off;
  assign w_e      = $signed({{(COORD_W-31){1'b0}}, cfg.cell_w});
  assign ht_e     = $signed({{(COORD_W-31){1'b0}}, cfg.cell_h});
  assign ox_e     = COORD_W'($signed(cfg.origin_x));
  assign oy_e     = COORD_W'($signed(cfg.origin_y));
  assign ytop_off = 34'(rows_m1) * 34'(cfg.cell_h);
  assign ytop_e   = oy_e + $signed({{(COORD_W-34){1'b0}}, ytop_off});

  // Intersection of the held rectangle with the current cell
  logic signed [COORD_W-1:0] ax_e, bx_e, ay_e, by_e, xa, xb, ya, yb, dx_w, dy_w;
  logic ovl;
  always_comb begin
    ax_e = COORD_W'(ax_r);
    bx_e = COORD_W'(bx_r);
    ay_e = COORD_W'(ay_r);
    by_e = COORD_W'(by_r);
    xa   = (ax_e > px_r) ? ax_e : px_r;
    xb   = (bx_e < qx_r) ? bx_e : qx_r;
    ya   = (ay_e > py_r) ? ay_e : py_r;
    yb   = (by_e < qy_r) ? by_e : qy_r;
    ovl  = (xa < xb) && (ya < yb);
    dx_w = xb - xa;
    dy_w = yb - ya;
  end

  logic step, col_end, grid_end;
  assign step     = (state_r == FR_WALK) && !q_stat.full;
  assign col_end  = (k_r == last_row_r);
  assign grid_end = col_end && (h_r == last_col_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_IDLE: begin
        if (accept) begin
          state_nxt = ((rows_c == 4'd0) || (cols_c == 4'd0)) ? FR_END : FR_WALK;
        end
      end
      FR_WALK: begin
        if (step && grid_end) state_nxt = FR_END;
      end
      FR_END: begin
        if (!q_stat.full) state_nxt = FR_IDLE;
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  // Queue writes
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    unique case (state_r)
      FR_WALK: begin
        push          = step && ovl;
        push_data.dx  = dx_w[31:0];
        push_data.dy  = dy_w[31:0];
        push_data.row = k_r;
        push_data.col = h_r;
      end
      FR_END: begin
        push             = !q_stat.full;
        push_data.is_end = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      h_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && (state_r == FR_IDLE)) begin
        h_r <= '0;
        k_r <= '0;
      end else if (step) begin
        if (col_end) begin
          k_r <= '0;
          h_r <= h_r + IDX_W'(1);
        end else begin
          k_r <= k_r + IDX_W'(1);
        end
      end
    end
  end

  // Rectangle, tags and cell edges
  always_ff @(posedge clk) begin
    if (accept && (state_r == FR_IDLE)) begin
      ax_r       <= in_data.src_x_lo;
      bx_r       <= in_data.src_x_hi;
      ay_r       <= in_data.src_y_lo;
      by_r       <= in_data.src_y_hi;
      tag_row_r  <= in_data.src_row;
      tag_col_r  <= in_data.src_col;
      last_row_r <= rows_m1;
      last_col_r <= cols_m1;
      px_r       <= ox_e;
      qx_r       <= ox_e + w_e;
      if (cfg.row_order) begin
        y0_r <= oy_e;
        y1_r <= oy_e + ht_e;
        py_r <= oy_e;
        qy_r <= oy_e + ht_e;
      end else begin
        y0_r <= ytop_e;
        y1_r <= ytop_e + ht_e;
        py_r <= ytop_e;
        qy_r <= ytop_e + ht_e;
      end
    end else if (step) begin
      if (col_end) begin
        px_r <= px_r + w_e;
        qx_r <= qx_r + w_e;
        py_r <= y0_r;
        qy_r <= y1_r;
      end else if (cfg.row_order) begin
        py_r <= py_r + ht_e;
        qy_r <= qy_r + ht_e;
      end else begin
        py_r <= py_r - ht_e;
        qy_r <= qy_r - ht_e;
      end
    end
  end

  assign tag_row = tag_row_r;
  assign tag_col = tag_col_r;

endmodule

FILE: sv/gcom_fifo.sv
// gcom_fifo: short queue of fragment words between the walker and the weight pipe.
// Uses gcom_pkg for the entry type and depth.
module gcom_fifo
  import gcom_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  gcom_frag_t   push_data,
  input  logic         pop,
  output gcom_frag_t   pop_data,
  output gcom_q_stat_t stat
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  gcom_frag_t mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  logic do_push, do_pop;
  assign stat.full  = (count_r == (PTR_W+1)'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (PTR_W+1)'(1);
        2'b01:   count_r <= count_r - (PTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("fragment queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(Q_DEPTH))
    else $error("fragment queue count out of range");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !stat.empty && !push) |=> (count_r == $past(count_r) - (PTR_W+1)'(1)))
    else $error("fragment queue count did not drop on read");
`endif

endmodule

FILE: sv/gcom_back.sv
// gcom_back: weight pipe. Area multiply, scale by feature per area in two halves,
// saturate, then hold one fragment back so the final one can carry last. Uses gcom_pkg.
module gcom_back
  import gcom_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  gcom_q_stat_t q_stat,
  output logic         pop,
  input  gcom_frag_t   pop_data,
  input  logic [31:0]  fpa,
  input  logic [7:0]   tag_row,
  input  logic [7:0]   tag_col,
  output logic         done,
  output logic         out_strobe,
  output gcom_out_t    out_data
);

  assign pop = !q_stat.empty;

  // Stage 1: overlap area, Q32.32
  logic v1_r, end1_r;
  logic [IDX_W-1:0] row1_r, col1_r;
  logic [63:0] area1_r;

  // Stage 2: scaled halves
  logic v2_r, end2_r;
  logic [IDX_W-1:0] row2_r, col2_r;
  logic [63:0] plo2_r, phi2_r;

  // Stage 3: weight, saturated
  logic v3_r, end3_r, sat3_r;
  logic [IDX_W-1:0] row3_r, col3_r;
  logic [47:0] wt3_r;

  // Held fragment and output word
  logic hold_v_r, hold_sat_r;
  logic [IDX_W-1:0] hold_row_r, hold_col_r;
  logic [47:0] hold_wt_r;
  logic out_strobe_r;
  gcom_out_t out_data_r;

  logic [64:0] wt_sum;
  logic        wt_sat;
  assign wt_sum = 65'(phi2_r) + 65'(plo2_r[63:32]);
  assign wt_sat = (wt_sum > 65'(WEIGHT_MAX));

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    end1_r  <= pop_data.is_end;
    row1_r  <= pop_data.row;
    col1_r  <= pop_data.col;
    area1_r <= 64'(pop_data.dx) * 64'(pop_data.dy);

    end2_r  <= end1_r;
    row2_r  <= row1_r;
    col2_r  <= col1_r;
    plo2_r  <= 64'(fpa) * 64'(area1_r[31:0]);
    phi2_r  <= 64'(fpa) * 64'(area1_r[63:32]);

    end3_r  <= end2_r;
    row3_r  <= row2_r;
    col3_r  <= col2_r;
    sat3_r  <= wt_sat;
    wt3_r   <= wt_sat ? WEIGHT_MAX : wt_sum[47:0];
  end

  logic frag_in, end_in;
  assign frag_in = v3_r && !end3_r;
  assign end_in  = v3_r && end3_r;
  assign done    = end_in;

  // Hold and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (frag_in && hold_v_r) || end_in;
      if (frag_in)     hold_v_r <= 1'b1;
      else if (end_in) hold_v_r <= 1'b0;
    end
  end

  // Hold and output payload
  always_ff @(posedge clk) begin
    if (frag_in) begin
      hold_row_r <= row3_r;
      hold_col_r <= col3_r;
      hold_wt_r  <= wt3_r;
      hold_sat_r <= sat3_r;
    end
    if ((frag_in && hold_v_r) || end_in) begin
      out_data_r.tag_row    <= tag_row;
      out_data_r.tag_col    <= tag_col;
      out_data_r.last       <= end_in;
      if (hold_v_r) begin
        out_data_r.tgt_row    <= hold_row_r;
        out_data_r.tgt_col    <= hold_col_r;
        out_data_r.weight     <= hold_wt_r;
        out_data_r.saturated  <= hold_sat_r;
        out_data_r.no_overlap <= 1'b0;
      end else begin
        out_data_r.tgt_row    <= '0;
        out_data_r.tgt_col    <= '0;
        out_data_r.weight     <= '0;
        out_data_r.saturated  <= 1'b0;
        out_data_r.no_overlap <= 1'b1;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef SYNTH
  a_hold_empty_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    end_in |=> !hold_v_r)
    else $error("held fragment left over after end marker");

  a_empty_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.no_overlap) |-> out_data.last)
    else $error("empty result without last");

  a_frag_out_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (frag_in && !hold_v_r) |=> !out_strobe)
    else $error("first fragment sent out before the next was seen");
`endif

endmodule

FILE: sv/grid_cell_overlap_mapper_unit.sv
// grid_cell_overlap_mapper_unit: top level. Config registers, busy flag, walker,
// fragment queue and weight pipe. Uses gcom_pkg, gcom_front, gcom_fifo, gcom_back.
//
// One source rectangle is taken when start is high and busy is low; busy then stays
// high until its final result is out. The walker in the front visits one target cell
// per clock while the fragment queue is not full, columns outer and rows inner.
// Results appear on out_data for one cycle each, marked by out_strobe, at most one
// per cycle, and must be taken as they come: the receiver cannot stall the block.
// The result with last set closes an item; busy is already low in that cycle, so
// the next start may be taken at its end. Configuration is written through
// cfg_valid/cfg_index/cfg_data (cfg_ready is always high); the user must write it
// only while busy is low, as the block itself does not enforce this. Indexes past
// the list are ignored.
module grid_cell_overlap_mapper_unit
  import gcom_pkg::*;
#(
  parameter int MAX_TGT_ROWS = MAX_TGT_ROWS_DEF,
  parameter int MAX_TGT_COLS = MAX_TGT_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  gcom_in_t             in_data,
  output logic                 out_strobe,
  output gcom_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  gcom_cfg_t cfg_r;
  logic busy_r;
  logic accept, done;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy_r;
  assign busy      = busy_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x  <= '0;
      cfg_r.origin_y  <= '0;
      cfg_r.cell_w    <= 31'd65536;
      cfg_r.cell_h    <= 31'd65536;
      cfg_r.rows      <= 4'd8;
      cfg_r.cols      <= 4'd8;
      cfg_r.fpa       <= 32'd65536;
      cfg_r.row_order <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X:  cfg_r.origin_x  <= $signed(cfg_data);
        CFG_ORIGIN_Y:  cfg_r.origin_y  <= $signed(cfg_data);
        CFG_CELL_W:    cfg_r.cell_w    <= cfg_data[30:0];
        CFG_CELL_H:    cfg_r.cell_h    <= cfg_data[30:0];
        CFG_ROWS:      cfg_r.rows      <= cfg_data[3:0];
        CFG_COLS:      cfg_r.cols      <= cfg_data[3:0];
        CFG_FPA:       cfg_r.fpa       <= cfg_data;
        CFG_ROW_ORDER: cfg_r.row_order <= cfg_data[0];
        default:       cfg_r.fpa       <= cfg_r.fpa;
      endcase
    end
  end

  // Busy from accept until the last result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  logic         push, pop;
  gcom_frag_t   push_data, pop_data;
  gcom_q_stat_t q_stat;
  logic [7:0]   tag_row, tag_col;

  gcom_front #(
    .MAX_TGT_ROWS (MAX_TGT_ROWS),
    .MAX_TGT_COLS (MAX_TGT_COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data),
    .tag_row   (tag_row),
    .tag_col   (tag_col)
  );

  gcom_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  gcom_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop        (pop),
    .pop_data   (pop_data),
    .fpa        (cfg_r.fpa),
    .tag_row    (tag_row),
    .tag_col    (tag_col),
    .done       (done),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after start");

  a_last_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last) |-> !busy)
    else $error("busy still high with the final result");

  a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last) |-> busy)
    else $error("result before last seen while not busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy_r))
    else $error("result without an item in flight");
`endif

endmodule
